FILE: src/biquad_lowpass_filter_top_macros.svh
// Assertion macros for the biquad low-pass filter.
`ifndef BIQUAD_LOWPASS_FILTER_TOP_MACROS_SVH
`define BIQUAD_LOWPASS_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define BLPF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset
`define BLPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define BLPF_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define BLPF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: src/blpf_pkg.sv
// Shared types and constants for the biquad low-pass filter.
package blpf_pkg;

   // Control register index
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_B0 = 2'd0,
      CSR_COEF_A1 = 2'd1,
      CSR_COEF_A2 = 2'd2,
      CSR_BYPASS  = 2'd3
   } csr_index_type;

endpackage

FILE: src/blpf_csr.sv
// Control registers: coefficients b0, a1, a2 and the bypass flag.
module blpf_csr #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [blpf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [COEF_FRAC_BITS+1:0]           csr_wdata,
   output logic [COEF_FRAC_BITS:0]             coef_b0,
   output logic signed [COEF_FRAC_BITS+1:0]    coef_a1,
   output logic signed [COEF_FRAC_BITS+1:0]    coef_a2,
   output logic                                bypass
);
   import blpf_pkg::*;

   logic [COEF_FRAC_BITS:0]          b0_ff, b0_in;
   logic signed [COEF_FRAC_BITS+1:0] a1_ff, a1_in;
   logic signed [COEF_FRAC_BITS+1:0] a2_ff, a2_in;
   logic                             bypass_ff, bypass_in;
   csr_index_type                    index;

   assign index = csr_index_type'(csr_index);

   // write decode; upper data bits beyond a register's width are dropped
   always_comb begin
      b0_in     = b0_ff;
      a1_in     = a1_ff;
      a2_in     = a2_ff;
      bypass_in = bypass_ff;
      if (csr_write_en) begin
         unique case (index)
            CSR_COEF_B0: b0_in     = csr_wdata[COEF_FRAC_BITS:0];
            CSR_COEF_A1: a1_in     = $signed(csr_wdata);
            CSR_COEF_A2: a2_in     = $signed(csr_wdata);
            CSR_BYPASS:  bypass_in = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff     <= '0;
         a1_ff     <= '0;
         a2_ff     <= '0;
         bypass_ff <= 1'b1;
      end else begin
         b0_ff     <= b0_in;
         a1_ff     <= a1_in;
         a2_ff     <= a2_in;
         bypass_ff <= bypass_in;
      end
   end

   assign coef_b0 = b0_ff;
   assign coef_a1 = a1_ff;
   assign coef_a2 = a2_ff;
   assign bypass  = bypass_ff;

endmodule

FILE: src/blpf_datapath.sv
// Biquad arithmetic: multiply-accumulate, round half up, saturate.
module blpf_datapath #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic signed [SAMPLE_BITS-1:0]      x,
   input  logic signed [SAMPLE_BITS-1:0]      x1,
   input  logic signed [SAMPLE_BITS-1:0]      x2,
   input  logic signed [SAMPLE_BITS-1:0]      y1,
   input  logic signed [SAMPLE_BITS-1:0]      y2,
   input  logic [COEF_FRAC_BITS:0]            coef_b0,
   input  logic signed [COEF_FRAC_BITS+1:0]   coef_a1,
   input  logic signed [COEF_FRAC_BITS+1:0]   coef_a2,
   output logic signed [SAMPLE_BITS-1:0]      y
);
   import blpf_pkg::*;

   // Full-precision sum fits in C+S+4 bits; beyond 64 bits it wraps at 64.
   localparam int FULL_W = SAMPLE_BITS + COEF_FRAC_BITS + 4;
   localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
   localparam int SUM_W  = SAMPLE_BITS + 2;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS =
      ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

   logic signed [SUM_W-1:0]  x_w, x1_w, x2_w, ff_sum;
   logic signed [ACC_W-1:0]  b0_ext, sum_ext, a1_ext, a2_ext, y1_ext, y2_ext;
   logic signed [ACC_W-1:0]  prod_b, prod_a1, prod_a2, acc, shifted;
   logic                     fits;

   // b1 = 2*b0 and b2 = b0, so the feedforward taps share one multiply
   assign x_w    = SUM_W'(x);
   assign x1_w   = SUM_W'(x1);
   assign x2_w   = SUM_W'(x2);
   assign ff_sum = x_w + (x1_w <<< 1) + x2_w;

   assign b0_ext  = $signed({{(ACC_W-COEF_FRAC_BITS-1){1'b0}}, coef_b0});
   assign sum_ext = ACC_W'(ff_sum);
   assign a1_ext  = ACC_W'(coef_a1);
   assign a2_ext  = ACC_W'(coef_a2);
   assign y1_ext  = ACC_W'(y1);
   assign y2_ext  = ACC_W'(y2);

   assign prod_b  = b0_ext * sum_ext;
   assign prod_a1 = a1_ext * y1_ext;
   assign prod_a2 = a2_ext * y2_ext;

   // accumulate with rounding bias, then floor shift
   assign acc     = prod_b - prod_a1 - prod_a2 + ROUND_BIAS;
   assign shifted = acc >>> COEF_FRAC_BITS;

   // in range when all bits from the output sign bit up agree
   assign fits = (&shifted[ACC_W-1:SAMPLE_BITS-1]) || !(|shifted[ACC_W-1:SAMPLE_BITS-1]);

   always_comb begin
      if (fits) begin
         y = shifted[SAMPLE_BITS-1:0];
      end else begin
         y = {shifted[ACC_W-1], {(SAMPLE_BITS-1){~shifted[ACC_W-1]}}};
      end
   end

endmodule

FILE: src/biquad_lowpass_filter_top.sv
// Biquad low-pass filter: handshake stages, sample history and datapath.
//
// Direct-form-I second-order low-pass filter. Throughput is one sample per
// clock while rsp_ready does not hold results back; a result becomes valid
// after passing the input register and then the result register. In the
// feedback loop, the datapath reads the output history that the previous
// sample wrote at the same edge that loaded its result. The first
// sample after reset primes all history with itself and passes through;
// after that the bypass register passes samples through without touching
// the history. Coefficients are fixed point with COEF_FRAC_BITS fraction
// bits: b0 unsigned, a1 and a2 signed; b1 = 2*b0 and b2 = b0 are formed
// internally. Write the control registers only while no request is in flight.
module biquad_lowpass_filter_top #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample_out,
   input  logic                              csr_write_en,
   input  logic [blpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [COEF_FRAC_BITS+1:0]         csr_wdata
);
   import blpf_pkg::*;

`include "biquad_lowpass_filter_top_macros.svh"

   logic [COEF_FRAC_BITS:0]          coef_b0;
   logic signed [COEF_FRAC_BITS+1:0] coef_a1, coef_a2;
   logic                             bypass;

   logic                         in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                         out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic                         primed_ff, primed_in;
   logic signed [SAMPLE_BITS-1:0] prev_in_1_ff, prev_in_1_in, prev_in_2_ff, prev_in_2_in;
   logic signed [SAMPLE_BITS-1:0] prev_out_1_ff, prev_out_1_in;
   logic signed [SAMPLE_BITS-1:0] prev_out_2_ff, prev_out_2_in;
   logic signed [SAMPLE_BITS-1:0] filt_y;
   logic                         adv, req_fire;

   blpf_csr #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coef_b0      (coef_b0),
      .coef_a1      (coef_a1),
      .coef_a2      (coef_a2),
      .bypass       (bypass)
   );

   blpf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .x       (x_ff),
      .x1      (prev_in_1_ff),
      .x2      (prev_in_2_ff),
      .y1      (prev_out_1_ff),
      .y2      (prev_out_2_ff),
      .coef_b0 (coef_b0),
      .coef_a1 (coef_a1),
      .coef_a2 (coef_a2),
      .y       (filt_y)
   );

   // stage handshake: compute fires when the result register is free or draining
   assign adv       = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;
   assign req_fire  = req_valid && req_ready;

   // input register
   always_comb begin
      x_in = x_ff;
      if (req_fire) begin
         x_in = req_sample_in;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // result select and history update
   always_comb begin
      out_in        = out_ff;
      primed_in     = primed_ff;
      prev_in_1_in  = prev_in_1_ff;
      prev_in_2_in  = prev_in_2_ff;
      prev_out_1_in = prev_out_1_ff;
      prev_out_2_in = prev_out_2_ff;
      if (adv) begin
         priority if (!primed_ff) begin
            out_in        = x_ff;
            primed_in     = 1'b1;
            prev_in_1_in  = x_ff;
            prev_in_2_in  = x_ff;
            prev_out_1_in = x_ff;
            prev_out_2_in = x_ff;
         end else if (bypass) begin
            out_in = x_ff;
         end else begin
            out_in        = filt_y;
            prev_in_1_in  = x_ff;
            prev_in_2_in  = prev_in_1_ff;
            prev_out_1_in = filt_y;
            prev_out_2_in = prev_out_1_ff;
         end
      end
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         primed_ff     <= 1'b0;
         prev_in_1_ff  <= '0;
         prev_in_2_ff  <= '0;
         prev_out_1_ff <= '0;
         prev_out_2_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         primed_ff     <= primed_in;
         prev_in_1_ff  <= prev_in_1_in;
         prev_in_2_ff  <= prev_in_2_in;
         prev_out_1_ff <= prev_out_1_in;
         prev_out_2_ff <= prev_out_2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_ff;

   // checks
   `BLPF_ASSERT_NEXT(a_prime_sets, clock, reset, adv && !primed_ff, primed_ff && rsp_valid)
   `BLPF_ASSERT_NEXT(a_bypass_pass, clock, reset, adv && primed_ff && bypass, rsp_sample_out == $past(x_ff) && prev_in_1_ff == $past(prev_in_1_ff))
   `BLPF_ASSERT_NEXT(a_hist_shift, clock, reset, adv && primed_ff && !bypass, prev_in_1_ff == $past(x_ff) && prev_out_1_ff == rsp_sample_out)
   `BLPF_ASSERT_IMPL(a_stall_cause, clock, reset, !req_ready, in_valid_ff && rsp_valid && !rsp_ready)

endmodule

FILE: sim/tb_biquad_lowpass_filter_top.sv
// Self-checking testbench for the biquad low-pass filter: directed table, random phases.
module tb_biquad_lowpass_filter_top;
   import blpf_pkg::*;

   localparam int SAMPLE_W     = 16;
   localparam int FRAC_W       = 16;
   localparam int CSR_W        = FRAC_W + 2;
   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES  = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 60;
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_MAX   = 25;
   localparam int SCRIPT_LEN   = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CSR_W-1:0] csr_word_type;

   typedef enum logic {ROW_SAMPLE, ROW_LOAD} row_kind_type;

   // One directed step: either a full register load or one request
   typedef struct {
      row_kind_type kind;
      csr_word_type w_b0;
      csr_word_type w_a1;
      csr_word_type w_a2;
      csr_word_type w_byp;
      sample_type   sample;
      bit           known;
      sample_type   result;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   sample_type    req_sample_in;
   logic          rsp_valid;
   logic          rsp_ready;
   sample_type    rsp_sample_out;
   logic          csr_write_en;
   csr_index_type csr_index;
   csr_word_type  csr_wdata;

   // Filter shadow: registers and history as the block should hold them
   logic [FRAC_W:0]           cfg_b0;
   logic signed [FRAC_W+1:0]  cfg_a1;
   logic signed [FRAC_W+1:0]  cfg_a2;
   logic                      cfg_bypass;
   sample_type                hist_x1, hist_x2, hist_y1, hist_y2;
   bit                        hist_primed;

   sample_type due_samples[$];
   sample_type due_now;
   sample_type filtered;
   int      bad_samples = 0;
   int      quiet_cycles = 0;
   int      walk_level = 0;

   // Directed-row override for the value of the current request
   bit         row_known;
   sample_type row_result;

   // Handshake pacing controls
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_rsp = 1'b0;

   script_row_type script [SCRIPT_LEN] = '{
      // reset state: first sample primes, then bypass
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh8000, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh7fff, 1'b1, 16'sh7fff},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd0, 1'b1, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd1, 1'b1, -16'sd1},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd1, 1'b1, 16'sd1},
      // zero coefficients; unused upper bits set
      '{ROW_LOAD, 18'h20000, 18'h0, 18'h0, 18'h3fffe, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd12345, 1'b1, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh8000, 1'b1, 16'sd0},
      // largest b0, no feedback: saturates both ways
      '{ROW_LOAD, 18'h1ffff, 18'h0, 18'h0, 18'h0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh8000, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh7fff, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh7fff, 1'b1, 16'sh7fff},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh7fff, 1'b1, 16'sh7fff},
      // Butterworth, cutoff at a tenth of the sample rate
      '{ROW_LOAD, 18'd4421, 18'h2db65, 18'd27053, 18'h0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd1000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd20000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh7fff, 1'b0, 16'sd0},
      // most negative feedback
      '{ROW_LOAD, 18'h0, 18'h20000, 18'h20000, 18'h0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd100, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd100, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd0, 1'b0, 16'sd0},
      // everything at its positive maximum
      '{ROW_LOAD, 18'h1ffff, 18'h1ffff, 18'h1ffff, 18'h0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh8000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sh7fff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd5, 1'b0, 16'sd0},
      // b0 = 0.5: odd sums land on halves, positive and negative
      '{ROW_LOAD, 18'd32768, 18'h0, 18'h0, 18'h0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd1, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd1, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, 16'sd2, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd4, 1'b0, 16'sd0},
      // bypass back on, upper bits set
      '{ROW_LOAD, 18'h0, 18'h0, 18'h0, 18'h3ffff, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 18'h0, 18'h0, 18'h0, 18'h0, -16'sd12345, 1'b1, -16'sd12345}
   };

   biquad_lowpass_filter_top #(
      .SAMPLE_BITS    (SAMPLE_W),
      .COEF_FRAC_BITS (FRAC_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // One filter step: priming, bypass, or DF-I sum with round and clamp
   function automatic sample_type biquad_step(input sample_type x);
      longint acc;
      longint y;
      sample_type y16;
      if (!hist_primed) begin
         hist_x1 = x;
         hist_x2 = x;
         hist_y1 = x;
         hist_y2 = x;
         hist_primed = 1'b1;
         return x;
      end
      if (cfg_bypass)
         return x;
      acc = longint'(cfg_b0) * longint'(x)
          + 2 * longint'(cfg_b0) * longint'(hist_x1)
          + longint'(cfg_b0) * longint'(hist_x2)
          - longint'(cfg_a1) * longint'(hist_y1)
          - longint'(cfg_a2) * longint'(hist_y2);
      acc += longint'(1) << (FRAC_W - 1);
      y = acc >>> FRAC_W;
      if (y > 32767)
         y16 = 16'sh7fff;
      else if (y < -32768)
         y16 = 16'sh8000;
      else
         y16 = sample_type'(y);
      hist_x2 = hist_x1;
      hist_x1 = x;
      hist_y2 = hist_y1;
      hist_y1 = y16;
      return y16;
   endfunction

   // Shadow registers, request prediction, result compare, watchdog
   always @(posedge clock) begin
      if (reset) begin
         cfg_b0 = '0;
         cfg_a1 = '0;
         cfg_a2 = '0;
         cfg_bypass = 1'b1;
         hist_x1 = '0;
         hist_x2 = '0;
         hist_y1 = '0;
         hist_y2 = '0;
         hist_primed = 1'b0;
         due_samples.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_COEF_B0: cfg_b0 = csr_wdata[FRAC_W:0];
               CSR_COEF_A1: cfg_a1 = csr_wdata;
               CSR_COEF_A2: cfg_a2 = csr_wdata;
               CSR_BYPASS:  cfg_bypass = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            filtered = biquad_step(req_sample_in);
            due_samples.push_back(row_known ? row_result : filtered);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_samples.size() == 0) begin
               bad_samples++;
               if (bad_samples <= REPORT_MAX)
                  $display("%0t: sample_out %0d with no request pending", $time,
                           rsp_sample_out);
            end else begin
               due_now = due_samples.pop_front();
               if (rsp_sample_out !== due_now) begin
                  bad_samples++;
                  if (bad_samples <= REPORT_MAX)
                     $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                              $time, due_now, rsp_sample_out);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= !(rsp_idle_on && $urandom_range(0, 99) < 17);
      end
   end

   // Present one request and hold it until accepted; returns on a falling edge
   task automatic send_sample(input sample_type x, input bit known,
                              input sample_type result);
      while (req_idle_on && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      row_known = known;
      row_result = result;
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop sending and wait for every pending result to drain
   task automatic settle();
      req_valid <= 1'b0;
      while (due_samples.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all four registers on consecutive cycles
   task automatic load_filter(input csr_word_type w_b0, input csr_word_type w_a1,
                              input csr_word_type w_a2, input csr_word_type w_byp);
      csr_write_en <= 1'b1;
      csr_index <= CSR_COEF_B0;
      csr_wdata <= w_b0;
      @(negedge clock);
      csr_index <= CSR_COEF_A1;
      csr_wdata <= w_a1;
      @(negedge clock);
      csr_index <= CSR_COEF_A2;
      csr_wdata <= w_a2;
      @(negedge clock);
      csr_index <= CSR_BYPASS;
      csr_wdata <= w_byp;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Per-phase setting: designed low-pass, random, extremes, bypass, mild feedback
   task automatic load_phase_setting(input int sel);
      csr_word_type b0, a1, a2;
      logic byp;
      b0 = {1'($urandom), 17'($urandom)};
      a1 = 18'($urandom);
      a2 = 18'($urandom);
      byp = 1'b0;
      case (sel % 5)
         0: begin
            case ($urandom_range(0, 2))
               0: begin b0[16:0] = 17'd4421;  a1 = 18'(-74907);  a2 = 18'd27053; end
               1: begin b0[16:0] = 17'd19195; a1 = 18'd0;        a2 = 18'd11244; end
               default: begin
                  b0[16:0] = 17'd237; a1 = 18'(-119451); a2 = 18'd54865;
               end
            endcase
         end
         1: ;
         2: begin
            b0[16:0] = $urandom_range(0, 1) ? 17'h1ffff : 17'h0;
            a1 = $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
            a2 = $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
         end
         3: byp = 1'b1;
         default: begin
            b0[16:0] = 17'($urandom_range(0, 8192));
            a1 = 18'(int'($urandom_range(0, 16384)) - 8192);
            a2 = 18'(int'($urandom_range(0, 16384)) - 8192);
         end
      endcase
      load_filter(b0, a1, a2, {17'($urandom), byp});
   endtask

   // Mix of extremes, full-range noise and a slow random walk
   function automatic sample_type pick_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0: walk_level = -32768;
            1: walk_level = 32767;
            2: walk_level = 0;
            default: walk_level = -1;
         endcase
      end else if (roll < 50) begin
         walk_level = int'($signed(16'($urandom)));
      end else begin
         walk_level += int'($urandom_range(0, 4000)) - 2000;
         if (walk_level > 32767)
            walk_level = 32767;
         if (walk_level < -32768)
            walk_level = -32768;
      end
      return sample_type'(walk_level);
   endfunction

   // Main sequence
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_COEF_B0;
      csr_wdata = '0;
      row_known = 1'b0;
      row_result = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_LOAD) begin
            settle();
            load_filter(script[i].w_b0, script[i].w_a1, script[i].w_a2, script[i].w_byp);
         end else begin
            send_sample(script[i].sample, script[i].known, script[i].result);
         end
      end

      // Random phases; one without idling, one with a long result hold-off
      for (int p = 0; p < PHASES; p++) begin
         settle();
         load_phase_setting(p);
         req_idle_on = (p != 2);
         rsp_idle_on = (p != 2);
         if (p == 6)
            hold_rsp = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(pick_sample(), 1'b0, 16'sd0);
      end

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (bad_samples == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
